// ===== rtl/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the relay scheduler
// Register indexes, field codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int SLOT_COUNT_DEF = 6;

    // Timer setup registers occupy indexes 0 up to SETUP_REGS-1
    localparam int SETUP_REGS = 6;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 22;
    localparam int SETUP_W     = 22;
    localparam int MODE_W      = 10;
    localparam int TIME_W      = 17;
    localparam int SLOT_NUM_W  = 3;
    localparam int ELAPSED_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_RELAY_ONE_MODE = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RELAY_TWO_MODE = 8'd7;

    localparam logic [TIME_W-1:0] LAST_SECOND = 17'd86399;

    // Relay mode codes
    localparam logic [1:0] MODE_HOLD = 2'd1;
    localparam logic [1:0] MODE_FLIP = 2'd2;

    // DO type codes
    localparam logic [1:0] DO_CLOSE   = 2'd0;
    localparam logic [1:0] DO_OPEN    = 2'd1;
    localparam logic [1:0] DO_INVERT  = 2'd2;
    localparam logic [1:0] DO_UNKNOWN = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the tick, advance elapsed counters
        logic do_pend;   // serve the pending hold or flip of the slot
        logic do_match;  // serve the time check of the slot
        logic flush;     // move the held result out as the last of the tick
    } trs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pend_fire;   // pending phase yields a result
        logic pend_hold;   // that result ends a hold
        logic match_fire;  // match phase yields a result
        logic can_emit;    // a new result can be taken now
        logic held_valid;  // a result waits for its successor
    } trs_status_t;

endpackage

// ===== rtl/trs_ctrl.sv =====
// ----------------------------------------------------------------------------
// trs_ctrl: slot sequencer of the relay scheduler
// Walks the timer slots in two phases each (no match phase where a hold ends) and closes every tick.
// ----------------------------------------------------------------------------
module trs_ctrl
    import trs_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick_valid,
    output logic              tick_ready,
    input  trs_status_t       status,
    output trs_cmd_t          cmd,
    output logic [SLOT_W-1:0] slot
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PEND  = 2'd1;
    localparam logic [1:0] ST_MATCH = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    assign slot       = slot_reg;
    assign tick_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (tick_valid) begin
                    cmd.load   = 1'b1;
                    slot_next  = '0;
                    state_next = ST_PEND;
                end
            end
            ST_PEND: begin
                if (!status.pend_fire || status.can_emit) begin
                    cmd.do_pend = 1'b1;
                    if (status.pend_fire && status.pend_hold) begin
                        // hold ended: skip the time check of this slot
                        if (slot_reg == LAST_SLOT) begin
                            state_next = ST_FLUSH;
                        end else begin
                            slot_next  = slot_reg + 1'b1;
                            state_next = ST_PEND;
                        end
                    end else begin
                        state_next = ST_MATCH;
                    end
                end
            end
            ST_MATCH: begin
                if (!status.match_fire || status.can_emit) begin
                    cmd.do_match = 1'b1;
                    if (slot_reg == LAST_SLOT) begin
                        state_next = ST_FLUSH;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_PEND;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.held_valid) begin
                    state_next = ST_IDLE;
                end else if (status.can_emit) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// ===== rtl/trs_datapath.sv =====
// ----------------------------------------------------------------------------
// trs_datapath: registers, slot state and result path of the relay scheduler
// Evaluates one slot phase per command and holds back one result so that
// the final result of a tick can be marked.
// ----------------------------------------------------------------------------
module trs_datapath
    import trs_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [TIME_W-1:0]      tick_time,
    input  trs_cmd_t               cmd,
    input  logic [SLOT_W-1:0]      slot,
    output trs_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_relay_select,
    output logic                   out_relay_level,
    output logic [SLOT_NUM_W-1:0]  out_slot_number,
    output logic                   out_restart_request,
    output logic                   out_last
);

    logic [SETUP_W-1:0]   timer_setup_reg  [SLOT_COUNT];
    logic [SETUP_W-1:0]   timer_setup_next [SLOT_COUNT];
    logic [MODE_W-1:0]    relay_mode_reg   [2];
    logic [MODE_W-1:0]    relay_mode_next  [2];
    logic                 slot_active_reg  [SLOT_COUNT];
    logic                 slot_active_next [SLOT_COUNT];
    logic                 saved_level_reg  [SLOT_COUNT];
    logic                 saved_level_next [SLOT_COUNT];
    logic [ELAPSED_W-1:0] slot_elapsed_reg [SLOT_COUNT];
    logic [ELAPSED_W-1:0] slot_elapsed_next[SLOT_COUNT];
    logic                 relay_levels_reg [2];
    logic                 relay_levels_next[2];
    logic [TIME_W-1:0]    now_reg, now_next;

    // held result and output register
    logic                  held_valid_reg, held_valid_next;
    logic                  held_relay_reg, held_relay_next;
    logic                  held_level_reg, held_level_next;
    logic [SLOT_NUM_W-1:0] held_slot_reg, held_slot_next;
    logic                  held_restart_reg, held_restart_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_relay_reg, out_relay_next;
    logic                  out_level_reg, out_level_next;
    logic [SLOT_NUM_W-1:0] out_slot_reg, out_slot_next;
    logic                  out_restart_reg, out_restart_next;
    logic                  out_last_reg, out_last_next;

    // fields of the current slot
    logic [SETUP_W-1:0]   setup;
    logic [TIME_W-1:0]    slot_time;
    logic                 enable;
    logic                 restart_act;
    logic                 relay;
    logic [1:0]           do_type;
    logic [MODE_W-1:0]    mode_word;
    logic [ELAPSED_W-1:0] period;
    logic [1:0]           mode;
    logic                 active;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 cur_level;
    logic                 timed_mode;
    logic                 near;
    logic                 pend_fire;
    logic                 pend_level;
    logic                 match_fire;
    logic                 match_level;
    logic                 out_free;
    logic                 new_valid;
    logic                 new_relay;
    logic                 new_level;
    logic                 new_restart;

    always_comb begin
        setup       = timer_setup_reg[slot];
        slot_time   = setup[16:0];
        enable      = setup[17];
        restart_act = setup[18];
        relay       = setup[19];
        do_type     = setup[21:20];
        mode_word   = relay_mode_reg[relay];
        period      = mode_word[7:0];
        mode        = mode_word[9:8];
        active      = slot_active_reg[slot];
        elapsed     = slot_elapsed_reg[slot];
        cur_level   = relay_levels_reg[relay];
        timed_mode  = (mode == MODE_HOLD) || (mode == MODE_FLIP);

        pend_fire   = enable && active && timed_mode && (elapsed >= period);
        pend_level  = (mode == MODE_HOLD) ? saved_level_reg[slot] : ~cur_level;

        // within one second, no wrap at midnight
        near = ({1'b0, now_reg} == {1'b0, slot_time})
            || ({1'b0, now_reg} == {1'b0, slot_time} + 18'd1)
            || ({1'b0, slot_time} == {1'b0, now_reg} + 18'd1);
        match_fire = enable && (slot_time <= LAST_SECOND) && near
            && (restart_act || (do_type != DO_UNKNOWN));
        unique case (do_type)
            DO_CLOSE: match_level = 1'b1;
            DO_OPEN:  match_level = 1'b0;
            default:  match_level = ~cur_level;
        endcase

        out_free = !out_valid_reg || out_ready;

        new_valid   = (cmd.do_pend && pend_fire) || (cmd.do_match && match_fire);
        new_restart = cmd.do_match && restart_act;
        new_relay   = new_restart ? 1'b0 : relay;
        new_level   = new_restart ? 1'b0 : (cmd.do_pend ? pend_level : match_level);
    end

    assign status.pend_fire  = pend_fire;
    assign status.pend_hold  = (mode == MODE_HOLD);
    assign status.match_fire = match_fire;
    assign status.can_emit   = !held_valid_reg || out_free;
    assign status.held_valid = held_valid_reg;

    always_comb begin
        timer_setup_next  = timer_setup_reg;
        relay_mode_next   = relay_mode_reg;
        slot_active_next  = slot_active_reg;
        saved_level_next  = saved_level_reg;
        slot_elapsed_next = slot_elapsed_reg;
        relay_levels_next = relay_levels_reg;
        now_next          = now_reg;

        if (cfg_write) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if ((i < SETUP_REGS) && (cfg_index == CFG_INDEX_W'(i))) begin
                    timer_setup_next[i] = cfg_data[SETUP_W-1:0];
                end
            end
            if (cfg_index == REG_RELAY_ONE_MODE) begin
                relay_mode_next[0] = cfg_data[MODE_W-1:0];
            end
            if (cfg_index == REG_RELAY_TWO_MODE) begin
                relay_mode_next[1] = cfg_data[MODE_W-1:0];
            end
        end

        if (cmd.load) begin
            now_next = tick_time;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slot_active_reg[i] && (slot_elapsed_reg[i] != '1)) begin
                    slot_elapsed_next[i] = slot_elapsed_reg[i] + 1'b1;
                end
            end
        end

        if (cmd.do_pend && pend_fire) begin
            relay_levels_next[relay] = pend_level;
            if (mode == MODE_HOLD) begin
                slot_active_next[slot] = 1'b0;
            end else begin
                slot_elapsed_next[slot] = '0;
            end
        end

        if (cmd.do_match && match_fire && !restart_act) begin
            if (!active) begin
                saved_level_next[slot] = cur_level;
            end
            relay_levels_next[relay] = match_level;
            if (timed_mode) begin
                slot_active_next[slot]  = 1'b1;
                slot_elapsed_next[slot] = '0;
            end
        end
    end

    // Result path: a new result pushes the held one out with last clear,
    // flush pushes it out with last set.
    always_comb begin
        held_valid_next   = held_valid_reg;
        held_relay_next   = held_relay_reg;
        held_level_next   = held_level_reg;
        held_slot_next    = held_slot_reg;
        held_restart_next = held_restart_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_relay_next    = out_relay_reg;
        out_level_next    = out_level_reg;
        out_slot_next     = out_slot_reg;
        out_restart_next  = out_restart_reg;
        out_last_next     = out_last_reg;

        if ((new_valid || cmd.flush) && held_valid_reg) begin
            out_valid_next   = 1'b1;
            out_relay_next   = held_relay_reg;
            out_level_next   = held_level_reg;
            out_slot_next    = held_slot_reg;
            out_restart_next = held_restart_reg;
            out_last_next    = cmd.flush;
        end

        if (new_valid) begin
            held_valid_next   = 1'b1;
            held_relay_next   = new_relay;
            held_level_next   = new_level;
            held_slot_next    = SLOT_NUM_W'(slot);
            held_restart_next = new_restart;
        end else if (cmd.flush) begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                timer_setup_reg[i]  <= '0;
                slot_active_reg[i]  <= 1'b0;
                saved_level_reg[i]  <= 1'b0;
                slot_elapsed_reg[i] <= '0;
            end
            for (int r = 0; r < 2; r++) begin
                relay_mode_reg[r]   <= '0;
                relay_levels_reg[r] <= 1'b0;
            end
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            timer_setup_reg  <= timer_setup_next;
            relay_mode_reg   <= relay_mode_next;
            slot_active_reg  <= slot_active_next;
            saved_level_reg  <= saved_level_next;
            slot_elapsed_reg <= slot_elapsed_next;
            relay_levels_reg <= relay_levels_next;
            held_valid_reg   <= held_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg          <= now_next;
        held_relay_reg   <= held_relay_next;
        held_level_reg   <= held_level_next;
        held_slot_reg    <= held_slot_next;
        held_restart_reg <= held_restart_next;
        out_relay_reg    <= out_relay_next;
        out_level_reg    <= out_level_next;
        out_slot_reg     <= out_slot_next;
        out_restart_reg  <= out_restart_next;
        out_last_reg     <= out_last_next;
    end

    assign out_valid           = out_valid_reg;
    assign out_relay_select    = out_relay_reg;
    assign out_relay_level     = out_level_reg;
    assign out_slot_number     = out_slot_reg;
    assign out_restart_request = out_restart_reg;
    assign out_last            = out_last_reg;

    // A flush only happens with a held result and a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> held_valid_reg && out_free)
        else $error("flush without held result or with busy output");

    // A new result never overruns the held one into a busy output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        new_valid && held_valid_reg |-> out_free)
        else $error("held result lost");

    // After a flush nothing is held for the next tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> !held_valid_reg)
        else $error("held result survives flush");

endmodule

// ===== rtl/time_of_day_relay_scheduler.sv =====
// ----------------------------------------------------------------------------
// time_of_day_relay_scheduler: six-slot time-of-day relay scheduler
// Serves hold and flip timing and time matches of each timer slot per tick.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  s_      | in        | s_tvalid/s_tready   | tick with time of day
//  m_      | out       | m_tvalid/m_tready   | relay command or restart request
//  cfg_    | in        | cfg_valid/cfg_ready | register index and write data
//
//  The slot sequencer walks each slot in a pending phase and a match phase,
//  one phase per cycle unless a result waits for the output; it skips the
//  match phase of a slot whose hold ends. The last result of a tick is held
//  back one step so it can carry m_tlast. A stall on m_ holds the sequencer
//  while a new result or the flush needs the busy output register.
//  Reset is synchronous: setup and mode registers, slot state, relay levels and valid flags go to 0.
//  cfg_ready is high outside reset; write registers only between ticks.
//
module time_of_day_relay_scheduler
    import trs_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // tick channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // [16:0] seconds_of_day
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [0] relay_select, [1] relay_level,
                                              // [4:2] slot_number
    output logic                   m_tuser,   // [0] restart_request
    output logic                   m_tlast,   // last_of_tick
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    trs_cmd_t              cmd;
    trs_status_t           status;
    logic [SLOT_W-1:0]     slot;
    logic                  relay_select;
    logic                  relay_level;
    logic [SLOT_NUM_W-1:0] slot_number;

    // accept every write outside reset: the register file never stalls
    assign cfg_ready = aresetn;

    trs_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_valid (s_tvalid),
        .tick_ready (s_tready),
        .status     (status),
        .cmd        (cmd),
        .slot       (slot)
    );

    trs_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_write           (cfg_valid & cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .tick_time           (s_tdata[TIME_W-1:0]),
        .cmd                 (cmd),
        .slot                (slot),
        .status              (status),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_relay_select    (relay_select),
        .out_relay_level     (relay_level),
        .out_slot_number     (slot_number),
        .out_restart_request (m_tuser),
        .out_last            (m_tlast)
    );

    // pack the command fields, pad to a whole byte
    assign m_tdata = {3'b000, slot_number, relay_level, relay_select};

endmodule

// ===== test/tb_time_of_day_relay_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_time_of_day_relay_scheduler: self-checking bench of the relay scheduler
// Drives one-second ticks and register writes, predicts every relay command
// and restart request in a behavioral copy of the slot state, and compares
// each result transaction field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_time_of_day_relay_scheduler;
    import trs_pkg::*;

    localparam int NUM_SLOTS     = SLOT_COUNT_DEF;
    localparam int IDLE_PCT      = 28;
    // Room for four full sequencer walks over all slots before touching registers
    localparam int DRAIN_CYCLES  = 4 * (2 * NUM_SLOTS + 2);
    localparam int HOLD_OFF_LEN  = 300;
    localparam int RUN_LIMIT     = 20_000_000;

    // Codes the package leaves unnamed
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd200;

    typedef struct packed {
        logic       relay;
        logic       level;
        logic [2:0] slot;
        logic       restart;
        logic       last;
    } relay_cmd_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow of the registers and slot state, updated per accepted transaction
    logic [SETUP_W-1:0] timer_reg  [NUM_SLOTS] = '{default: '0};
    logic [MODE_W-1:0]  mode_reg   [2]         = '{default: '0};
    logic               slot_busy  [NUM_SLOTS] = '{default: '0};
    logic               slot_saved [NUM_SLOTS] = '{default: '0};
    logic [ELAPSED_W-1:0] slot_age [NUM_SLOTS] = '{default: '0};
    logic               relay_now  [2]         = '{default: '0};

    relay_cmd_t  relay_cmds_due[$];
    int unsigned mismatch_count = 0;
    int unsigned cmds_seen      = 0;
    bit          steady_run     = 1'b0;

    // Receiver hold-off: bump stall_req to start one long stretch
    int unsigned stall_len  = 0;
    int unsigned stall_req  = 0;
    int unsigned stall_ack  = 0;
    int unsigned stall_left = 0;

    always #10 aclk = ~aclk;

    time_of_day_relay_scheduler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at command %0d: got %0d, want %0d",
                 field, cmds_seen, got, want);
        mismatch_count++;
    endtask

    function automatic logic [SETUP_W-1:0] pack_timer(input int t, input bit en,
                                                      input bit restart, input bit relay,
                                                      input logic [1:0] dot);
        logic [TIME_W-1:0] tt;
        tt = t[TIME_W-1:0];
        return {dot, relay, restart, en, tt};
    endfunction

    function automatic logic [MODE_W-1:0] pack_mode(input int period, input logic [1:0] md);
        logic [7:0] p;
        p = period[7:0];
        return {md, p};
    endfunction

    // Work out the commands of one tick: elapsed counters first, then each
    // slot in order with its pending hold or flip ahead of its time match.
    function automatic void run_schedule(input logic [TIME_W-1:0] now);
        relay_cmd_t        tick_cmds[$];
        logic [SETUP_W-1:0] w;
        logic [TIME_W-1:0] slot_time;
        logic              rel;
        logic [1:0]        md;
        logic [7:0]        period;
        logic              lvl;
        logic              known;
        logic              hold_done;
        int                gap;
        for (int s = 0; s < NUM_SLOTS; s++)
            if (slot_busy[s] && slot_age[s] != 8'hFF) slot_age[s]++;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w         = timer_reg[s];
            slot_time = w[TIME_W-1:0];
            rel       = w[19];
            md        = mode_reg[rel][9:8];
            period    = mode_reg[rel][7:0];
            hold_done = 1'b0;
            if (w[17]) begin
                if (slot_busy[s] && slot_age[s] >= period) begin
                    if (md == MODE_HOLD) begin
                        tick_cmds.push_back('{rel, slot_saved[s], 3'(s), 1'b0, 1'b0});
                        relay_now[rel] = slot_saved[s];
                        slot_busy[s]   = 1'b0;
                        hold_done      = 1'b1;
                    end else if (md == MODE_FLIP) begin
                        relay_now[rel] = ~relay_now[rel];
                        tick_cmds.push_back('{rel, relay_now[rel], 3'(s), 1'b0, 1'b0});
                        slot_age[s] = '0;
                    end
                end
                // plain distance, no wrap at midnight
                gap = int'(now) - int'(slot_time);
                if (gap < 0) gap = -gap;
                if (!hold_done && slot_time <= LAST_SECOND && gap <= 1) begin
                    if (w[18]) begin
                        tick_cmds.push_back('{1'b0, 1'b0, 3'(s), 1'b1, 1'b0});
                    end else begin
                        known = 1'b1;
                        lvl   = 1'b0;
                        case (w[21:20])
                            DO_CLOSE:  lvl = 1'b1;
                            DO_OPEN:   lvl = 1'b0;
                            DO_INVERT: lvl = ~relay_now[rel];
                            default:   known = 1'b0;
                        endcase
                        if (known) begin
                            if (!slot_busy[s]) slot_saved[s] = relay_now[rel];
                            relay_now[rel] = lvl;
                            tick_cmds.push_back('{rel, lvl, 3'(s), 1'b0, 1'b0});
                            if (md == MODE_HOLD || md == MODE_FLIP) begin
                                slot_busy[s] = 1'b1;
                                slot_age[s]  = '0;
                            end
                        end
                    end
                end
            end
        end
        if (tick_cmds.size() != 0) tick_cmds[tick_cmds.size()-1].last = 1'b1;
        foreach (tick_cmds[i]) relay_cmds_due.push_back(tick_cmds[i]);
    endfunction

    // Write one register; leave cfg_valid high so back-to-back writes chain
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < SETUP_REGS) timer_reg[idx] = val[SETUP_W-1:0];
        else if (idx == REG_RELAY_ONE_MODE) mode_reg[0] = val[MODE_W-1:0];
        else if (idx == REG_RELAY_TWO_MODE) mode_reg[1] = val[MODE_W-1:0];
    endtask

    // Offer one tick; s_tvalid stays high after the transaction so the
    // next call in the same step can present its data without a gap.
    task automatic send_tick(input logic [TIME_W-1:0] sec);
        cfg_valid <= 1'b0;
        if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, sec};
        do @(posedge aclk); while (!s_tready);
        run_schedule(sec);
    endtask

    // Drop both request lines, wait for every predicted command, then let
    // a tick that yields nothing run out before registers change.
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (relay_cmds_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SETUP_W-1:0] random_timer(input int base);
        int         t;
        logic [1:0] dot;
        t = base + int'($urandom_range(10)) - 2;
        if (t < 0) t = 0;
        if (t > int'(LAST_SECOND)) t = int'(LAST_SECOND);
        if ($urandom_range(99) < 5) t = int'($urandom_range(131071, 86400));
        dot = ($urandom_range(99) < 10) ? DO_UNKNOWN : 2'($urandom_range(2));
        return pack_timer(t, $urandom_range(99) < 85, $urandom_range(99) < 8,
                          1'($urandom_range(1)), dot);
    endfunction

    function automatic logic [MODE_W-1:0] random_mode();
        int r;
        int per;
        r = $urandom_range(99);
        if (r < 70) per = $urandom_range(5);
        else if (r < 85) per = 255;
        else per = $urandom_range(255);
        return pack_mode(per, 2'($urandom_range(3)));
    endfunction

    // Every DO type, restart, disabled slot, out-of-day slot time, midnight
    // without wrap and tick values above the last second of the day.
    task automatic test_directed_actions();
        write_reg(REG_UNUSED, '1);
        write_reg(0, pack_timer(0, 1, 0, 0, DO_CLOSE));
        write_reg(1, pack_timer(1, 1, 0, 1, DO_INVERT));
        write_reg(2, pack_timer(86399, 1, 1, 0, DO_CLOSE));
        write_reg(3, pack_timer(131071, 1, 0, 0, DO_OPEN));
        write_reg(4, pack_timer(5, 1, 0, 1, DO_UNKNOWN));
        write_reg(5, pack_timer(0, 0, 0, 1, DO_CLOSE));
        write_reg(REG_RELAY_ONE_MODE, pack_mode(0, MODE_NONE));
        write_reg(REG_RELAY_TWO_MODE, pack_mode(255, MODE_NONE));
        send_tick(17'd0);
        send_tick(17'd2);
        send_tick(17'd4);
        send_tick(17'd6);
        send_tick(17'd86399);
        send_tick(17'd86398);
        send_tick(17'd86400);
        send_tick(17'd131071);
        send_tick(17'd65536);
        send_tick(17'd1);
        wait_idle();
    endtask

    // Hold and flip timing, repeated matches while a slot is pending,
    // then the spare mode code, a zero-period hold and an all-ones setup.
    task automatic test_directed_modes();
        write_reg(0, pack_timer(1000, 1, 0, 0, DO_CLOSE));
        write_reg(1, pack_timer(1000, 1, 0, 1, DO_OPEN));
        write_reg(2, pack_timer(1003, 1, 0, 0, DO_INVERT));
        write_reg(3, pack_timer(1000, 1, 1, 1, DO_CLOSE));
        write_reg(4, '0);
        write_reg(5, '0);
        write_reg(REG_RELAY_ONE_MODE, pack_mode(2, MODE_HOLD));
        write_reg(REG_RELAY_TWO_MODE, pack_mode(0, MODE_FLIP));
        for (int t = 999; t <= 1005; t++) send_tick(17'(t));
        wait_idle();
        write_reg(REG_RELAY_ONE_MODE, pack_mode(255, MODE_SPARE));
        write_reg(REG_RELAY_TWO_MODE, pack_mode(0, MODE_HOLD));
        write_reg(4, pack_timer(1010, 1, 0, 1, DO_INVERT));
        write_reg(5, '1);
        send_tick(17'd1010);
        send_tick(17'd1011);
        send_tick(17'd1012);
        wait_idle();
    endtask

    // Every slot fires up to twice per tick; stall the receiver long enough that
    // the block backs up onto its tick input, then pause until drained.
    task automatic test_backpressure();
        for (int s = 0; s < NUM_SLOTS; s++)
            write_reg(s, pack_timer(30000, 1, 0, 1'(s), DO_INVERT));
        write_reg(REG_RELAY_ONE_MODE, pack_mode(0, MODE_FLIP));
        write_reg(REG_RELAY_TWO_MODE, pack_mode(0, MODE_FLIP));
        stall_len <= HOLD_OFF_LEN;
        stall_req <= stall_req + 1;
        send_tick(17'd29999);
        send_tick(17'd30000);
        send_tick(17'd30000);
        send_tick(17'd30001);
        send_tick(17'd30001);
        send_tick(17'd30002);
        wait_idle();
    endtask

    // Keep a held slot disabled past 255 ticks so its elapsed count must
    // saturate; re-enabled with a 255 s hold it has to restore at once.
    task automatic test_elapsed_saturation();
        int base;
        base = 50000;
        write_reg(0, pack_timer(base, 1, 0, 0, DO_CLOSE));
        write_reg(1, pack_timer(base, 1, 0, 1, DO_CLOSE));
        for (int s = 2; s < NUM_SLOTS; s++) write_reg(s, random_timer(base + 100));
        write_reg(REG_RELAY_ONE_MODE, pack_mode(200, MODE_HOLD));
        write_reg(REG_RELAY_TWO_MODE, pack_mode(3, MODE_FLIP));
        send_tick(17'(base));
        wait_idle();
        write_reg(0, pack_timer(base, 0, 0, 0, DO_CLOSE));
        steady_run = 1'b1;
        for (int i = 1; i <= 262; i++) begin
            if (i == 130) steady_run = 1'b0;
            send_tick(17'(base + i));
        end
        wait_idle();
        write_reg(REG_RELAY_ONE_MODE, pack_mode(255, MODE_HOLD));
        write_reg(0, pack_timer(base, 1, 0, 0, DO_CLOSE));
        send_tick(17'(base + 263));
        wait_idle();
    endtask

    // Runs of consecutive seconds around randomly placed slot times, with
    // repeated seconds and stray ticks mixed in; slot state carries over.
    task automatic test_random_schedules(input int unsigned ticks_wanted);
        int unsigned sent;
        int          base;
        int          now;
        int          r;
        sent = 0;
        while (sent < ticks_wanted) begin
            wait_idle();
            r = $urandom_range(99);
            if (r < 15) base = $urandom_range(3);
            else if (r < 30) base = $urandom_range(86399, 86396);
            else base = $urandom_range(86399);
            for (int s = 0; s < NUM_SLOTS; s++)
                if ($urandom_range(99) < 70) write_reg(s, random_timer(base));
            if ($urandom_range(99) < 70) write_reg(REG_RELAY_ONE_MODE, random_mode());
            if ($urandom_range(99) < 70) write_reg(REG_RELAY_TWO_MODE, random_mode());
            now = base - int'($urandom_range(3));
            if (now < 0) now = 0;
            repeat ($urandom_range(18, 6)) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    send_tick(17'($urandom_range(86399)));
                end else begin
                    send_tick(17'(now));
                    // hold the second now and then, advance otherwise
                    if (r >= 14 && now < int'(LAST_SECOND)) now++;
                end
                sent++;
            end
        end
    endtask

    // Receiver: random idling, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (stall_req != stall_ack) begin
            stall_ack  <= stall_req;
            stall_left <= stall_len;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each result transaction with the oldest predicted command
    always @(posedge aclk) begin
        relay_cmd_t got;
        relay_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[1], m_tdata[4:2], m_tuser, m_tlast};
            if (relay_cmds_due.size() == 0) begin
                report_mismatch("unrequested command", 1, 0);
            end else begin
                want = relay_cmds_due.pop_front();
                if (got.relay !== want.relay)
                    report_mismatch("relay_select", got.relay, want.relay);
                if (got.level !== want.level)
                    report_mismatch("relay_level", got.level, want.level);
                if (got.slot !== want.slot)
                    report_mismatch("slot_number", got.slot, want.slot);
                if (got.restart !== want.restart)
                    report_mismatch("restart_request", got.restart, want.restart);
                if (got.last !== want.last)
                    report_mismatch("last_of_tick", got.last, want.last);
            end
            cmds_seen++;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_actions();
        test_directed_modes();
        test_backpressure();
        test_elapsed_saturation();
        test_random_schedules(60);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/trs_pkg.sv
rtl/trs_ctrl.sv
rtl/trs_datapath.sv
rtl/time_of_day_relay_scheduler.sv
test/tb_time_of_day_relay_scheduler.sv
